FILE: design/sfp_pkg.sv
package sfp_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE      = 8'hAA;
  localparam logic [7:0] TAIL_BYTE     = 8'hAB;
  localparam logic [7:0] CMD_MEASURE   = 8'hC0;
  localparam logic [7:0] CMD_REPLY     = 8'hC5;

  // Reply sub-types carried in data byte 0
  localparam logic [7:0] REPLY_REPORT  = 8'h02;
  localparam logic [7:0] REPLY_SLEEP   = 8'h06;

  // Byte positions inside a frame (0 = hunting for header)
  localparam logic [3:0] POS_HUNT      = 4'd0;
  localparam logic [3:0] POS_CMD       = 4'd1;
  localparam logic [3:0] POS_DATA_FIRST = 4'd2;
  localparam logic [3:0] POS_DATA_KEEP = 4'd5;  // last data byte kept in the record
  localparam logic [3:0] POS_DATA_LAST = 4'd7;
  localparam logic [3:0] POS_SUM       = 4'd8;
  localparam logic [3:0] POS_TAIL      = 4'd9;

  // Decoupling queue depth between assembler and decoder
  localparam int QUEUE_DEPTH = 2;

  // Data bytes carried from the assembler to the decoder
  localparam int KEPT_BYTES = 4;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CHECKSUM = 2'd1,
    STAT_UNKNOWN  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_SLEEP   = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLS_MEASURE = 2'd0,
    CLS_REPLY   = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cmd_class_t;

  // One completed frame with a good tail
  typedef struct packed {
    logic                          sum_bad;
    cmd_class_t                    cls;
    logic [KEPT_BYTES-1:0][7:0]    data;
  } frame_rec_t;

endpackage

FILE: design/sfp_ifs.sv
interface sfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [1:0]  msg_kind;
  logic [15:0] pm25_reading;
  logic [15:0] pm10_reading;
  logic [7:0]  reply_value;
  logic        reply_is_set;
  logic        answer_seen;

  modport source (output valid, output frame_status, output msg_kind, output pm25_reading,
                  output pm10_reading, output reply_value, output reply_is_set,
                  output answer_seen, input ready);
  modport sink   (input valid, input frame_status, input msg_kind, input pm25_reading,
                  input pm10_reading, input reply_value, input reply_is_set,
                  input answer_seen, output ready);
endinterface

FILE: design/sfp_front.sv
module sfp_front (
  input  logic                  clk,
  input  logic                  rst,
  sfp_rx_if.sink                rx,
  input  logic                  q_full,
  output logic                  q_push,
  output sfp_pkg::frame_rec_t   q_data
);

  logic [3:0]                                pos;
  logic [7:0]                                sum;
  logic                                      sum_bad;
  sfp_pkg::cmd_class_t                       cls;
  logic [sfp_pkg::KEPT_BYTES-1:0][7:0]       data;

  logic       accept;
  logic [3:0] data_off;
  logic [1:0] data_idx;

  // Only the tail beat needs queue room
  assign rx.ready = !((pos == sfp_pkg::POS_TAIL) && q_full);
  assign accept   = rx.valid && rx.ready;

  assign data_off = pos - sfp_pkg::POS_DATA_FIRST;
  assign data_idx = data_off[1:0];

  // Good tail: hand the frame to the decoder
  assign q_push       = accept && (pos == sfp_pkg::POS_TAIL) && (rx.rx_byte == sfp_pkg::TAIL_BYTE);
  assign q_data.sum_bad = sum_bad;
  assign q_data.cls     = cls;
  assign q_data.data    = data;

  // Position counter and checksum tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= sfp_pkg::POS_HUNT;
      sum     <= 8'd0;
      sum_bad <= 1'b0;
    end else if (accept) begin
      priority if (pos == sfp_pkg::POS_CMD) begin
        pos <= pos + 4'd1;
      end else if (pos >= sfp_pkg::POS_DATA_FIRST && pos <= sfp_pkg::POS_DATA_LAST) begin
        sum <= sum + rx.rx_byte;
        pos <= pos + 4'd1;
      end else if (pos == sfp_pkg::POS_SUM) begin
        sum_bad <= (rx.rx_byte != sum);
        pos     <= sfp_pkg::POS_TAIL;
      end else if (pos == sfp_pkg::POS_TAIL) begin
        pos <= sfp_pkg::POS_HUNT;
      end else begin
        // hunting (and any stray position)
        if (rx.rx_byte == sfp_pkg::HDR_BYTE) begin
          pos     <= sfp_pkg::POS_CMD;
          sum     <= 8'd0;
          sum_bad <= 1'b0;
        end else begin
          pos <= sfp_pkg::POS_HUNT;
        end
      end
    end
  end

  // Frame contents: command class and the data bytes the decoder needs
  always_ff @(posedge clk) begin
    if (accept && pos == sfp_pkg::POS_CMD) begin
      priority if (rx.rx_byte == sfp_pkg::CMD_MEASURE) cls <= sfp_pkg::CLS_MEASURE;
      else if (rx.rx_byte == sfp_pkg::CMD_REPLY)       cls <= sfp_pkg::CLS_REPLY;
      else                                             cls <= sfp_pkg::CLS_UNKNOWN;
    end
    if (accept && pos >= sfp_pkg::POS_DATA_FIRST && pos <= sfp_pkg::POS_DATA_KEEP) begin
      data[data_idx] <= rx.rx_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= sfp_pkg::POS_TAIL)
    else $error("frame position out of range");

  a_push_rehunt: assert property (@(posedge clk) disable iff (rst)
    q_push |=> pos == sfp_pkg::POS_HUNT)
    else $error("parser did not return to hunting after a frame");

  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

endmodule

FILE: design/sfp_fifo.sv
module sfp_fifo #(
  parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfp_pkg::frame_rec_t  wr_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 rd_valid,
  output sfp_pkg::frame_rec_t  rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_pkg::frame_rec_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

FILE: design/sfp_back.sv
module sfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  sfp_pkg::frame_rec_t  q_data,
  output logic                 q_pop,
  sfp_res_if.source            res
);

  logic [7:0] query_mode;

  sfp_pkg::status_t status_c;
  sfp_pkg::kind_t   kind_c;
  logic [15:0]      pm25_c;
  logic [15:0]      pm10_c;
  logic [7:0]       value_c;
  logic             set_c;
  logic             answer_c;
  logic             report_c;

  // Output register frees when empty or being taken
  assign q_pop = q_valid && (!res.valid || res.ready);

  // Decode one frame record
  always_comb begin
    status_c = sfp_pkg::STAT_OK;
    kind_c   = sfp_pkg::KIND_MEASURE;
    pm25_c   = 16'd0;
    pm10_c   = 16'd0;
    value_c  = 8'd0;
    set_c    = 1'b0;
    answer_c = 1'b0;
    report_c = 1'b0;
    if (q_data.sum_bad) begin
      status_c = sfp_pkg::STAT_CHECKSUM;
    end else begin
      unique case (q_data.cls)
        sfp_pkg::CLS_MEASURE: begin
          pm25_c   = {q_data.data[1], q_data.data[0]};
          pm10_c   = {q_data.data[3], q_data.data[2]};
          answer_c = (query_mode != 8'd0);
        end
        sfp_pkg::CLS_REPLY: begin
          priority if (q_data.data[0] == sfp_pkg::REPLY_REPORT) begin
            kind_c   = sfp_pkg::KIND_REPORT;
            report_c = 1'b1;
          end else if (q_data.data[0] == sfp_pkg::REPLY_SLEEP) begin
            kind_c = sfp_pkg::KIND_SLEEP;
          end else begin
            kind_c = sfp_pkg::KIND_OTHER;
          end
          value_c  = q_data.data[2];
          set_c    = (q_data.data[1] != 8'd0);
          answer_c = set_c;
        end
        default: begin
          status_c = sfp_pkg::STAT_UNKNOWN;
        end
      endcase
    end
  end

  // Result valid and stored query mode
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid  <= 1'b0;
      query_mode <= 8'd0;
    end else begin
      if (q_pop)          res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      if (q_pop && report_c) query_mode <= q_data.data[2];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.frame_status <= status_c;
      res.msg_kind     <= kind_c;
      res.pm25_reading <= pm25_c;
      res.pm10_reading <= pm10_c;
      res.reply_value  <= value_c;
      res.reply_is_set <= set_c;
      res.answer_seen  <= answer_c;
    end
  end

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_status != sfp_pkg::STAT_OK) |->
      (res.pm25_reading == 16'd0 && res.pm10_reading == 16'd0 && res.reply_value == 8'd0 &&
       res.reply_is_set == 1'b0 && res.answer_seen == 1'b0))
    else $error("error result carries data");

  a_mode_on_pop: assert property (@(posedge clk) disable iff (rst)
    !$stable(query_mode) |-> $past(q_pop))
    else $error("query mode changed without a frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.frame_status != 2'd3)
    else $error("illegal frame status");

endmodule

FILE: design/sensor_frame_parser.sv
// Channel   Dir  Payload                                         Handshake
// rx        in   rx_byte[7:0]                                    valid/ready
// res       out  frame_status, msg_kind, pm25_reading,           valid/ready
//                pm10_reading, reply_value, reply_is_set,
//                answer_seen
//
// One byte per cycle is taken while the assembler is not stalled; a frame's result is
// written into the frame queue on its tail beat, then into the output register.
// The assembler stalls only on a tail beat while the frame queue is full.
// The queue (QUEUE_DEPTH frames) plus the output register absorb result back-pressure.
// rst is synchronous: parser returns to hunting, queue empties, query mode clears.
module sensor_frame_parser #(
  parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  sfp_rx_if.sink      rx,
  sfp_res_if.source   res
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  sfp_pkg::frame_rec_t q_wr;
  sfp_pkg::frame_rec_t q_rd;

  // Byte hunting and frame assembly
  sfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  // Frame queue
  sfp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  // Frame decode and result register
  sfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded frame as it leaves the parser
  typedef struct packed {
    sfp_pkg::status_t status;
    sfp_pkg::kind_t   kind;
    logic [15:0]      pm25;
    logic [15:0]      pm10;
    logic [7:0]       value;
    logic             set_flag;
    logic             answered;
  } frame_result_t;

  typedef enum int {RCV_OPEN, RCV_CHOPPY, RCV_CHOKED} rcv_mode_t;

  function automatic string show_frame(frame_result_t f);
    return $sformatf("status=%0d kind=%0d pm25=%h pm10=%h value=%h set=%b answered=%b",
                     f.status, f.kind, f.pm25, f.pm10, f.value, f.set_flag, f.answered);
  endfunction

  // Tracks the frame assembler and holds the decoded frames still owed by the DUT
  class frame_predictor;
    logic [3:0]    pos;
    logic [7:0]    cmd;
    logic [7:0]    data [6];
    logic [7:0]    sum;
    bit            sum_bad;
    logic [7:0]    query_mode;
    frame_result_t pending_frames [$];
    int            mismatches;

    function new();
      pos        = sfp_pkg::POS_HUNT;
      cmd        = '0;
      foreach (data[i]) data[i] = '0;
      sum        = '0;
      sum_bad    = 1'b0;
      query_mode = '0;
      mismatches = 0;
    endfunction

    // Called on every accepted rx beat
    function void take_byte(logic [7:0] b);
      frame_result_t r;
      if (pos == sfp_pkg::POS_HUNT || pos > sfp_pkg::POS_TAIL) begin
        if (b == sfp_pkg::HDR_BYTE) begin
          pos     = sfp_pkg::POS_CMD;
          sum     = '0;
          sum_bad = 1'b0;
        end else begin
          pos = sfp_pkg::POS_HUNT;
        end
      end else if (pos == sfp_pkg::POS_CMD) begin
        cmd = b;
        pos = sfp_pkg::POS_DATA_FIRST;
      end else if (pos <= sfp_pkg::POS_DATA_LAST) begin
        data[pos - sfp_pkg::POS_DATA_FIRST] = b;
        sum = sum + b;
        pos = pos + 4'd1;
      end else if (pos == sfp_pkg::POS_SUM) begin
        sum_bad = (b != sum);
        pos     = sfp_pkg::POS_TAIL;
      end else begin
        // tail beat: a bad tail drops the frame with no result
        pos = sfp_pkg::POS_HUNT;
        if (b == sfp_pkg::TAIL_BYTE) begin
          r = '0;
          if (sum_bad) begin
            r.status = sfp_pkg::STAT_CHECKSUM;
          end else if (cmd == sfp_pkg::CMD_MEASURE) begin
            r.pm25     = {data[1], data[0]};
            r.pm10     = {data[3], data[2]};
            r.answered = (query_mode != 8'd0);
          end else if (cmd == sfp_pkg::CMD_REPLY) begin
            if (data[0] == sfp_pkg::REPLY_REPORT) begin
              r.kind     = sfp_pkg::KIND_REPORT;
              query_mode = data[2];
            end else if (data[0] == sfp_pkg::REPLY_SLEEP) begin
              r.kind = sfp_pkg::KIND_SLEEP;
            end else begin
              r.kind = sfp_pkg::KIND_OTHER;
            end
            r.value    = data[2];
            r.set_flag = (data[1] != 8'd0);
            r.answered = r.set_flag;
          end else begin
            r.status = sfp_pkg::STAT_UNKNOWN;
          end
          pending_frames.push_back(r);
        end
      end
    endfunction

    // Called on every accepted result beat
    function void match_frame(frame_result_t got);
      frame_result_t exp_f;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame result: %s", show_frame(got));
        return;
      end
      exp_f = pending_frames.pop_front();
      if (got.status !== exp_f.status || got.kind !== exp_f.kind ||
          got.pm25 !== exp_f.pm25 || got.pm10 !== exp_f.pm10 ||
          got.value !== exp_f.value || got.set_flag !== exp_f.set_flag ||
          got.answered !== exp_f.answered) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame mismatch at %0t", $realtime);
          $display("  expected: %s", show_frame(exp_f));
          $display("  actual:   %s", show_frame(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic rcv_ready = 1'b0;

  sfp_rx_if  rx_ch();
  sfp_res_if res_ch();

  frame_predictor frames;

  int burst_left  = 0;
  int frame_bytes = 0;  // rx beats accepted so far
  int drain_wait;
  int pick;
  int noise_len;
  rcv_mode_t rcv_mode = RCV_OPEN;
  int rcv_left = 0;

  sensor_frame_parser DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  assign res_ch.ready = rcv_ready;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("sensor_frame_parser test failed");
    $finish;
  end

  // Receiver: switches between open, choppy and mostly stalled stretches
  always @(posedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode = rcv_mode_t'($urandom_range(0, 2));
      rcv_left = $urandom_range(20, 200);
    end
    rcv_left--;
    case (rcv_mode)
      RCV_OPEN:   rcv_ready <= 1'b1;
      RCV_CHOPPY: rcv_ready <= 1'($urandom_range(0, 1));
      default:    rcv_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      frames.match_frame('{status:   sfp_pkg::status_t'(res_ch.frame_status),
                           kind:     sfp_pkg::kind_t'(res_ch.msg_kind),
                           pm25:     res_ch.pm25_reading,
                           pm10:     res_ch.pm10_reading,
                           value:    res_ch.reply_value,
                           set_flag: res_ch.reply_is_set,
                           answered: res_ch.answer_seen});
  end

  // Send one beat; the sender runs in bursts with idle gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0)
        burst_left = $urandom_range(40, 150);
      else
        burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    frames.take_byte(b);
    frame_bytes++;
    burst_left--;
  endtask

  // Full frame; sum_flip corrupts the checksum, tail may be wrong on purpose
  task automatic send_frame(input logic [7:0] cmd, input logic [5:0][7:0] pl,
                            input logic [7:0] sum_flip, input logic [7:0] tail);
    logic [7:0] chk;
    chk = '0;
    for (int i = 0; i < 6; i++) chk = chk + pl[i];
    send_byte(sfp_pkg::HDR_BYTE);
    send_byte(cmd);
    for (int i = 0; i < 6; i++) send_byte(pl[i]);
    send_byte(chk ^ sum_flip);
    send_byte(tail);
  endtask

  // Random frame content, biased toward the known commands and reply types
  task automatic send_random_frame();
    logic [7:0]      cmd;
    logic [5:0][7:0] pl;
    logic [7:0]      sum_flip;
    logic [7:0]      tail;
    pl = 48'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0, 1:    cmd = sfp_pkg::CMD_MEASURE;
      2, 3:    cmd = sfp_pkg::CMD_REPLY;
      default: cmd = 8'($urandom_range(0, 255));
    endcase
    if (cmd == sfp_pkg::CMD_REPLY) begin
      case ($urandom_range(0, 2))
        0:       pl[0] = sfp_pkg::REPLY_REPORT;
        1:       pl[0] = sfp_pkg::REPLY_SLEEP;
        default: pl[0] = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 1) == 0) pl[1] = 8'd0;
      if ($urandom_range(0, 3) == 0) pl[2] = 8'd0;
    end
    sum_flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    tail     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : sfp_pkg::TAIL_BYTE;
    send_frame(cmd, pl, sum_flip, tail);
  endtask

  initial begin
    frames        = new();
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: noise while hunting, every command and reply type, error cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(sfp_pkg::CMD_MEASURE, {6{8'hFF}}, 8'h00, sfp_pkg::TAIL_BYTE);
    send_frame(sfp_pkg::CMD_REPLY, {8'h11, 8'h22, 8'h33, 8'h05, 8'h00, sfp_pkg::REPLY_REPORT},
               8'h00, sfp_pkg::TAIL_BYTE);
    send_frame(sfp_pkg::CMD_MEASURE, {6{8'h00}}, 8'h00, sfp_pkg::TAIL_BYTE);
    send_frame(sfp_pkg::CMD_REPLY, {8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, sfp_pkg::REPLY_SLEEP},
               8'h00, sfp_pkg::TAIL_BYTE);
    send_frame(sfp_pkg::CMD_REPLY, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h33}, 8'h00,
               sfp_pkg::TAIL_BYTE);
    // checksum error wins over the command decode
    send_frame(sfp_pkg::CMD_REPLY, {8'h01, 8'h02, 8'h03, 8'h04, 8'h01, sfp_pkg::REPLY_REPORT},
               8'h80, sfp_pkg::TAIL_BYTE);
    send_frame(8'hFF, {8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60}, 8'h00, sfp_pkg::TAIL_BYTE);
    // bad tail: frame dropped silently
    send_frame(sfp_pkg::CMD_MEASURE, {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}, 8'h00,
               sfp_pkg::HDR_BYTE);
    // report reply clears the query mode again
    send_frame(sfp_pkg::CMD_REPLY, {8'hAB, 8'hAA, 8'hFF, 8'h00, 8'h80, sfp_pkg::REPLY_REPORT},
               8'h00, sfp_pkg::TAIL_BYTE);

    // Random: mostly well-formed frames, some noise and truncated frames
    while (frame_bytes < 1000) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_random_frame();
      end else if (pick < 93) begin
        noise_len = $urandom_range(1, 6);
        repeat (noise_len) send_byte(8'($urandom_range(0, 255)));
      end else begin
        noise_len = $urandom_range(1, 8);
        send_byte(sfp_pkg::HDR_BYTE);
        repeat (noise_len) send_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_ch.valid <= 1'b0;

    // Drain outstanding results
    drain_wait = 0;
    while (frames.pending_frames.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);

    if (frames.mismatches == 0 && frames.pending_frames.size() == 0) begin
      $display("sensor_frame_parser test passed");
    end else begin
      $display("sensor_frame_parser test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sfp_pkg.sv
design/sfp_ifs.sv
design/sfp_front.sv
design/sfp_fifo.sv
design/sfp_back.sv
design/sensor_frame_parser.sv
sim/tb_top.sv
